// ===== hdl/wmf_pkg.sv =====
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared types and constants of the weighted 3x3 median filter.
// ----------------------------------------------------------------------------
package wmf_pkg;

	localparam int WIN_DIM     = 3;
	localparam int WIN_TAPS    = WIN_DIM * WIN_DIM;
	localparam int CENTRE_TAP  = WIN_TAPS / 2;
	localparam int PIX_W       = 8;
	localparam int WEIGHT_W    = 4;
	localparam int WEIGHTS_W   = WIN_TAPS * WEIGHT_W;
	localparam int SUM_W       = 8;
	localparam int LW_W        = 11;
	localparam int FH_W        = 12;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 36;
	localparam int MIN_DIM     = 3;
	localparam int LS_W        = 2 * PIX_W;

	localparam logic [LW_W-1:0]      LINE_WIDTH_RST   = 11'd640;
	localparam logic [FH_W-1:0]      FRAME_HEIGHT_RST = 12'd480;
	localparam logic [WEIGHTS_W-1:0] WEIGHTS_RST      = 36'h111111111;

	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_WIDTH     = 2'd0,
		REG_FRAME_HEIGHT   = 2'd1,
		REG_WINDOW_WEIGHTS = 2'd2
	} cfg_reg_t;

	// One full window handed to the median unit, taps row-major from the
	// top-left, tap 0 in the low bits.
	typedef struct packed {
		pix_t [WIN_TAPS-1:0] pix;
		logic                last;
	} win_req_t;

endpackage

// ===== hdl/wmf_line_store.sv =====
// ----------------------------------------------------------------------------
// wmf_line_store
// Line memory: one word per column holds the pixels of the two previous lines.
// ----------------------------------------------------------------------------
module wmf_line_store
	import wmf_pkg::*;
#(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output logic [LS_W-1:0] rd_data,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  logic [LS_W-1:0] wr_data
);

	logic [LS_W-1:0] mem [DEPTH];
	logic [LS_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read returns the contents before a write at the same edge.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/wmf_median_unit.sv =====
// ----------------------------------------------------------------------------
// wmf_median_unit
// Three-stage weighted median: rank compare, weight prefix sums, selection.
// ----------------------------------------------------------------------------
module wmf_median_unit
	import wmf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  win_req_t             win,
	input  logic                 win_valid,
	output logic                 win_ready,
	input  logic [WEIGHTS_W-1:0] weights,
	output logic                 res_valid,
	input  logic                 res_stall,
	output pix_t                 median,
	output logic                 last_in_frame
);

	logic out_ready, s4_ready, s3_ready;

	// Stage 3: ordering matrix. bef[i][j] says tap j sorts ahead of tap i
	// (smaller value, or equal value and lower index).
	logic [WIN_TAPS-1:0][WIN_TAPS-1:0] bef;
	logic [SUM_W-1:0]                  tot;

	logic                              vld_s3;
	logic [WIN_TAPS-1:0][WIN_TAPS-1:0] bef_s3;
	pix_t [WIN_TAPS-1:0]               val_s3;
	logic [WIN_TAPS-1:0][WEIGHT_W-1:0] wt_s3;
	logic [SUM_W-1:0]                  tot_s3;
	logic                              last_s3;

	// Stage 4: weight of everything sorted ahead of each tap.
	logic [WIN_TAPS-1:0][SUM_W-1:0]    below;

	logic                              vld_s4;
	logic [WIN_TAPS-1:0][SUM_W-1:0]    below_s4;
	pix_t [WIN_TAPS-1:0]               val_s4;
	logic [WIN_TAPS-1:0][WEIGHT_W-1:0] wt_s4;
	logic [SUM_W-1:0]                  tgt_s4;
	logic                              zero_s4;
	logic                              last_s4;

	logic [WIN_TAPS-1:0] hit;
	pix_t                sel;

	logic res_valid_q;
	pix_t median_q;
	logic last_q;

	assign out_ready = !res_valid_q || !res_stall;
	assign s4_ready  = !vld_s4 || out_ready;
	assign s3_ready  = !vld_s3 || s4_ready;
	assign win_ready = s3_ready;

	always_comb begin
		tot = '0;
		for (int i = 0; i < WIN_TAPS; i++) begin
			tot = tot + SUM_W'(weights[WEIGHT_W*i +: WEIGHT_W]);
			for (int j = 0; j < WIN_TAPS; j++) begin
				bef[i][j] = (i != j) && ((win.pix[j] < win.pix[i]) ||
					((win.pix[j] == win.pix[i]) && (j < i)));
			end
		end
	end

	always_comb begin
		for (int i = 0; i < WIN_TAPS; i++) begin
			below[i] = '0;
			for (int j = 0; j < WIN_TAPS; j++) begin
				if (bef_s3[i][j]) begin
					below[i] = below[i] + SUM_W'(wt_s3[j]);
				end
			end
		end
	end

	// If any weight is set, exactly one tap of nonzero weight covers the target.
	always_comb begin
		sel = '0;
		for (int i = 0; i < WIN_TAPS; i++) begin
			hit[i] = (wt_s4[i] != '0) && (below_s4[i] <= tgt_s4) &&
				(tgt_s4 < below_s4[i] + SUM_W'(wt_s4[i]));
			if (hit[i]) begin
				sel = sel | val_s4[i];
			end
		end
		if (zero_s4) begin
			sel = val_s4[CENTRE_TAP];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s3_ready) begin
				vld_s3 <= win_valid;
			end
			if (s4_ready) begin
				vld_s4 <= vld_s3;
			end
			if (out_ready) begin
				res_valid_q <= vld_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s3_ready && win_valid) begin
			bef_s3  <= bef;
			val_s3  <= win.pix;
			wt_s3   <= weights;
			tot_s3  <= tot;
			last_s3 <= win.last;
		end
		if (s4_ready && vld_s3) begin
			below_s4 <= below;
			val_s4   <= val_s3;
			wt_s4    <= wt_s3;
			tgt_s4   <= tot_s3 >> 1;
			zero_s4  <= (tot_s3 == '0);
			last_s4  <= last_s3;
		end
		if (out_ready && vld_s4) begin
			median_q <= sel;
			last_q   <= last_s4;
		end
	end

	assign res_valid     = res_valid_q;
	assign median        = median_q;
	assign last_in_frame = last_q;

endmodule

// ===== hdl/weighted_median_filter_core.sv =====
// ----------------------------------------------------------------------------
// weighted_median_filter_core
// Streaming weighted 3x3 median filter for 8-bit gray pixels.
// ----------------------------------------------------------------------------
// Usage. Pixels enter in raster order on the pix channel (pixel, frame_start),
// one request per cycle when pix_valid is high and pix_stall is low. Set
// frame_start on the first pixel of a frame; the counters also wrap on their
// own after the configured frame size. For every window that lies fully inside
// the frame, one result (median, last_in_frame) leaves on the res channel; the
// window is centred one line up and one column left of the newest pixel. No
// result is made for the first two lines and the first two columns.
// Throughput is one pixel per cycle while pix_stall is low. On its way to
// the ports a pixel passes the line memory read, the window shift, the
// rank compare, the weight prefix sums and the output register.
// When the receiver stalls, the result holds in the output register and the
// stages behind it keep filling until each holds a result; only then is
// pix_stall raised. The line memory reads and writes one column word per
// pixel; a pixel reading the column its predecessor is writing takes the
// data by forwarding. Configuration writes go to the cfg channel, which is
// always ready, and should be made while no pixel is in flight.
// Reset clears counters, window and pipeline valids and loads 640x480 with
// all weights one; the line memory is not cleared and needs no startup pass.
// ----------------------------------------------------------------------------
module weighted_median_filter_core
	import wmf_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  pix_t                  pixel,
	input  logic                  frame_start,
	output logic                  res_valid,
	input  logic                  res_stall,
	output pix_t                  median,
	output logic                  last_in_frame,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Column index width, and a width that holds both the line width register
	// and MAX_WIDTH itself.
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int WW = (CW > LW_W) ? CW : LW_W;

	// Configuration registers.
	logic [LW_W-1:0]      line_width_q;
	logic [FH_W-1:0]      frame_height_q;
	logic [WEIGHTS_W-1:0] weights_q;
	logic                 cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= LINE_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			weights_q      <= WEIGHTS_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LINE_WIDTH:     line_width_q   <= cfg_data[LW_W-1:0];
				REG_FRAME_HEIGHT:   frame_height_q <= cfg_data[FH_W-1:0];
				REG_WINDOW_WEIGHTS: weights_q      <= cfg_data[WEIGHTS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Effective frame size: width clamped into 3..MAX_WIDTH, height to at
	// least 3.
	logic [WW-1:0]   lw_x;
	logic [WW-1:0]   eff_w;
	logic [FH_W-1:0] eff_h;

	always_comb begin
		lw_x = WW'(line_width_q);
		if (lw_x < WW'(MIN_DIM)) begin
			eff_w = WW'(MIN_DIM);
		end else if (lw_x > WW'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = lw_x;
		end
		eff_h = (frame_height_q < FH_W'(MIN_DIM)) ? FH_W'(MIN_DIM) : frame_height_q;
	end

	// Position counters and the decisions taken for the pixel being accepted.
	logic [AW-1:0]   col_q;
	logic [FH_W-1:0] row_q;
	logic [AW-1:0]   c_in;
	logic [FH_W-1:0] r_in;
	logic [WW-1:0]   c_x;
	logic            col_wrap;
	logic            row_wrap;
	logic            emit_in;
	logic            last_in;
	logic            pix_acc;

	always_comb begin
		c_in     = frame_start ? '0 : col_q;
		r_in     = frame_start ? '0 : row_q;
		c_x      = WW'(c_in);
		col_wrap = (c_x + WW'(1)) >= eff_w;
		row_wrap = ({1'b0, r_in} + (FH_W+1)'(1)) >= {1'b0, eff_h};
		emit_in  = (r_in >= FH_W'(2)) && (c_x >= WW'(2));
		last_in  = (r_in == eff_h - FH_W'(1)) && (c_x == eff_w - WW'(1));
	end

	// Stage 1 holds the accepted pixel while its line memory read completes.
	logic       vld_s1;
	pix_t       px_s1;
	logic [AW-1:0] col_s1;
	logic       emit_s1;
	logic       last_s1;
	logic       fwd_s1;
	pix_t       fwd_top_s1;
	pix_t       fwd_mid_s1;

	logic [LS_W-1:0] ls_rd_data;
	pix_t            top_s1;
	pix_t            mid_s1;
	logic            s1_adv;

	// Stage 2 is the window itself; vld_s2 marks a window that owes a result.
	pix_t [WIN_TAPS-1:0] win_q;
	logic                vld_s2;
	logic                last_s2;
	logic                s2_ready;
	logic                med_ready;
	win_req_t            win_req;

	assign s2_ready  = !vld_s2 || med_ready;
	assign s1_adv    = vld_s1 && s2_ready;
	assign pix_stall = vld_s1 && !s2_ready;
	assign pix_acc   = pix_valid && !pix_stall;

	// The previous pixel writes its column at the same edge that this pixel
	// reads it; in that case the read data is stale and the forwarded copy
	// is used instead.
	assign top_s1 = fwd_s1 ? fwd_top_s1 : ls_rd_data[LS_W-1:PIX_W];
	assign mid_s1 = fwd_s1 ? fwd_mid_s1 : ls_rd_data[PIX_W-1:0];

	wmf_line_store #(
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk    (clk),
		.rd_en  (pix_acc),
		.rd_addr(c_in),
		.rd_data(ls_rd_data),
		.wr_en  (s1_adv),
		.wr_addr(col_s1),
		.wr_data({mid_s1, px_s1})
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			win_q  <= '0;
		end else begin
			if (pix_acc) begin
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : r_in + FH_W'(1);
				end else begin
					col_q <= c_in + AW'(1);
					row_q <= r_in;
				end
			end
			if (!pix_stall) begin
				vld_s1 <= pix_valid;
			end
			if (s2_ready) begin
				vld_s2 <= vld_s1 && emit_s1;
			end
			if (s1_adv) begin
				for (int r = 0; r < WIN_DIM; r++) begin
					win_q[r*WIN_DIM]     <= win_q[r*WIN_DIM + 1];
					win_q[r*WIN_DIM + 1] <= win_q[r*WIN_DIM + 2];
				end
				win_q[WIN_DIM - 1]       <= top_s1;
				win_q[2*WIN_DIM - 1]     <= mid_s1;
				win_q[WIN_TAPS - 1]      <= px_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			px_s1      <= pixel;
			col_s1     <= c_in;
			emit_s1    <= emit_in;
			last_s1    <= last_in;
			fwd_s1     <= s1_adv && (c_in == col_s1);
			fwd_top_s1 <= mid_s1;
			fwd_mid_s1 <= px_s1;
		end
		if (s1_adv) begin
			last_s2 <= last_s1;
		end
	end

	assign win_req.pix  = win_q;
	assign win_req.last = last_s2;

	wmf_median_unit u_median (
		.clk          (clk),
		.arst_n       (arst_n),
		.win          (win_req),
		.win_valid    (vld_s2),
		.win_ready    (med_ready),
		.weights      (weights_q),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.median       (median),
		.last_in_frame(last_in_frame)
	);

	// A pixel in the first two lines of a frame never owes a result.
	a_no_result_top_rows: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_acc && !frame_start && (row_q < FH_W'(2))) |=> !emit_s1)
		else $error("result scheduled for a pixel in the first two lines");

	// Without a width change, the column counter stays inside the line.
	a_col_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_acc && !cfg_we) |=> (WW'(col_q) < eff_w))
		else $error("column counter beyond the effective line width");

	// A frame start puts the next pixel at column one of row zero.
	a_frame_start_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_acc && frame_start) |=> ((col_q == AW'(1)) && (row_q == '0)))
		else $error("counters not restarted by frame start");

endmodule

// ===== dv/tb_weighted_median_filter_core.sv =====
// ----------------------------------------------------------------------------
// tb_weighted_median_filter_core
// Self-checking bench for the streaming weighted 3x3 median filter.
// ----------------------------------------------------------------------------
// A queue of pixel requests feeds a clocked driver, and a clocked monitor
// checks every result against a line-store and window model kept inside the
// bench. The run covers the power-on geometry, a few directed frames, a long
// output hold-off, many small random frames with random weights, a very tall
// frame and a start at the widest line. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_weighted_median_filter_core;
	import wmf_pkg::*;

	localparam int MAX_W        = 1024;
	localparam int GAP_MAX      = 16;
	localparam int TAIL_CYCLES  = 12;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_ITEMS = 450;
	localparam int DRAIN_LIMIT  = 20000;

	// Index 3 is not a register; writes to it must leave the block unchanged.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef enum int {
		WT_RANDOM,
		WT_UNIT,
		WT_ZERO,
		WT_SINGLE,
		WT_FULL,
		WT_LIGHT
	} weight_mode_e;

	// One pixel request as the driver offers it, with its idle lead-in.
	typedef struct {
		pix_t value;
		logic first;
		int   gap;
	} pixel_req_t;

	// One filtered window as the monitor expects it.
	typedef struct {
		pix_t median;
		logic last;
	} median_res_t;

	logic                  clk;
	logic                  arst_n;
	logic                  pix_valid;
	logic                  pix_stall;
	pix_t                  pixel;
	logic                  frame_start;
	logic                  res_valid;
	logic                  res_stall;
	pix_t                  median;
	logic                  last_in_frame;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Requests still to be offered, and medians still to be seen.
	pixel_req_t  pixel_queue[$];
	median_res_t median_queue[$];

	// Driver state. The request being offered stays in cur_req until the
	// rising edge that takes it; pix_taken carries that news to the driver.
	pixel_req_t cur_req;
	bit         cur_loaded;
	int         cur_wait;
	bit         pix_taken;

	// Receiver state. rx_wait is the per-result stall draw; hold_left is the
	// long hold-off that the main sequence arms once.
	bit res_taken;
	int rx_wait;
	int hold_left;
	bit rx_quiet;

	// Filter model: configuration, line store, window and raster position.
	logic [LW_W-1:0]      width_reg;
	logic [FH_W-1:0]      height_reg;
	logic [WEIGHTS_W-1:0] weight_reg;
	pix_t                 line_mem [0:2*MAX_W-1];
	pix_t [WIN_TAPS-1:0]  win_taps;
	int                   col_pos;
	int                   row_pos;

	median_res_t got_want;
	int          errors;

	weighted_median_filter_core #(
		.MAX_WIDTH(MAX_W)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix_valid    (pix_valid),
		.pix_stall    (pix_stall),
		.pixel        (pixel),
		.frame_start  (frame_start),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.median       (median),
		.last_in_frame(last_in_frame),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// The weighted median is the smallest weighted tap value whose cumulative
	// weight, counting every tap at or below it, passes half the total. With
	// no weight at all the centre tap passes through unchanged.
	function automatic pix_t weighted_pick(input pix_t [WIN_TAPS-1:0] taps,
			input logic [WEIGHTS_W-1:0] wts);
		int   total;
		int   target;
		int   cum;
		pix_t pick;
		bit   found;
		total = 0;
		pick  = '0;
		found = 1'b0;
		for (int i = 0; i < WIN_TAPS; i++)
			total += wts[WEIGHT_W*i +: WEIGHT_W];
		if (total == 0)
			return taps[CENTRE_TAP];
		target = total / 2;
		for (int i = 0; i < WIN_TAPS; i++) begin
			if (wts[WEIGHT_W*i +: WEIGHT_W] != 0) begin
				cum = 0;
				for (int j = 0; j < WIN_TAPS; j++)
					if (taps[j] <= taps[i])
						cum += wts[WEIGHT_W*j +: WEIGHT_W];
				if (cum > target && (!found || taps[i] < pick)) begin
					pick  = taps[i];
					found = 1'b1;
				end
			end
		end
		return pick;
	endfunction

	// Advances the model by one accepted pixel and queues the median that the
	// pixel completes, if its window lies fully inside the frame.
	task automatic filter_pixel(input pix_t px, input logic fs);
		int          w;
		int          h;
		int          c;
		pix_t        top;
		pix_t        mid;
		median_res_t res;
		// Out-of-range geometry is clamped rather than rejected.
		w = (width_reg < MIN_DIM) ? MIN_DIM : ((width_reg > MAX_W) ? MAX_W : width_reg);
		h = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		c = col_pos % MAX_W;
		// The lower half of the store holds the previous line, the upper half
		// the line before it; each pixel pushes its column down one line.
		top = line_mem[MAX_W + c];
		mid = line_mem[c];
		line_mem[MAX_W + c] = mid;
		line_mem[c] = px;
		for (int k = 0; k < WIN_DIM; k++) begin
			win_taps[k*WIN_DIM]     = win_taps[k*WIN_DIM + 1];
			win_taps[k*WIN_DIM + 1] = win_taps[k*WIN_DIM + 2];
		end
		win_taps[WIN_DIM - 1]   = top;
		win_taps[2*WIN_DIM - 1] = mid;
		win_taps[3*WIN_DIM - 1] = px;
		// The first two lines and the first two columns make no window.
		if (row_pos >= 2 && col_pos >= 2) begin
			res.median = weighted_pick(win_taps, weight_reg);
			res.last   = (row_pos == h - 1) && (col_pos == w - 1);
			median_queue.push_back(res);
		end
		// The raster wraps on its own, so a new frame begins even without
		// frame_start.
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
	endtask

	// Monitor and model update share one block so that the check of a result
	// and the prediction for a new pixel at the same edge happen in a fixed
	// order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				res_taken = 1'b1;
				if (median_queue.size() == 0) begin
					$error("result with no pending window: median %0d last_in_frame %0b",
						median, last_in_frame);
					errors++;
				end else begin
					got_want = median_queue.pop_front();
					if (median !== got_want.median) begin
						$error("median: expected %0d, actual %0d", got_want.median, median);
						errors++;
					end
					if (last_in_frame !== got_want.last) begin
						$error("last_in_frame: expected %0b, actual %0b",
							got_want.last, last_in_frame);
						errors++;
					end
				end
			end
			if (pix_valid && !pix_stall) begin
				pix_taken = 1'b1;
				filter_pixel(pixel, frame_start);
			end
		end
	end

	// Pixel driver. A request that is offered stays up with the same payload
	// until taken; the next one is loaded only after that, and it first waits
	// out its own idle gap with valid low.
	always @(negedge clk) begin
		if (pix_taken) begin
			pix_taken  = 1'b0;
			cur_loaded = 1'b0;
		end
		if (!cur_loaded && pixel_queue.size() != 0) begin
			cur_req    = pixel_queue.pop_front();
			cur_loaded = 1'b1;
			cur_wait   = cur_req.gap;
		end
		if (cur_loaded && cur_wait == 0) begin
			pix_valid   <= 1'b1;
			pixel       <= cur_req.value;
			frame_start <= cur_req.first;
		end else begin
			if (cur_wait > 0)
				cur_wait--;
			pix_valid <= 1'b0;
		end
	end

	// Result receiver. After each result it stalls for a random number of
	// cycles, unless the phase runs without idling; the long hold-off counts
	// down here independently of the pixel side.
	always @(negedge clk) begin
		if (res_taken) begin
			res_taken = 1'b0;
			rx_wait   = rx_quiet ? 0 : $urandom_range(0, GAP_MAX);
		end
		res_stall <= (rx_wait > 0) || (hold_left > 0);
		if (rx_wait > 0)
			rx_wait--;
		if (hold_left > 0)
			hold_left--;
	end

	// Waits until every request has been taken and every median has arrived,
	// then lets the pipeline run empty past any pixel that made no result.
	task automatic wait_drained();
		do @(posedge clk);
		while (pixel_queue.size() != 0 || cur_loaded || median_queue.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Writes one register and mirrors the write in the model once the write
	// request has been taken. Valid stays high between back-to-back writes.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_LINE_WIDTH:     width_reg  = data[LW_W-1:0];
			REG_FRAME_HEIGHT:   height_reg = data[FH_W-1:0];
			REG_WINDOW_WEIGHTS: weight_reg = data[WEIGHTS_W-1:0];
			default: ;
		endcase
	endtask

	// Starts a phase: waits for an idle block, then writes all registers. The
	// bits above each register's width carry random junk, which the block
	// must drop, and now and then the unused index gets a write as well.
	task automatic setup(input logic [LW_W-1:0] lw, input logic [FH_W-1:0] fh,
			input logic [WEIGHTS_W-1:0] wts, input bit quiet);
		logic [CFG_DATA_W-1:0] junk;
		wait_drained();
		rx_quiet     = quiet;
		junk[31:0]   = $urandom;
		junk[35:32]  = WEIGHT_W'($urandom_range(0, 15));
		if (junk[0])
			cfg_write(REG_SPARE, junk);
		cfg_write(REG_LINE_WIDTH, {junk[CFG_DATA_W-1:LW_W], lw});
		cfg_write(REG_FRAME_HEIGHT, {junk[CFG_DATA_W-1:FH_W], fh});
		cfg_write(REG_WINDOW_WEIGHTS, wts);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [WEIGHTS_W-1:0] pick_weights();
		logic [WEIGHTS_W-1:0] w;
		weight_mode_e         mode;
		int                   tap;
		w    = '0;
		mode = weight_mode_e'($urandom_range(0, 5));
		tap  = $urandom_range(0, WIN_TAPS - 1);
		case (mode)
			WT_RANDOM: begin
				w[31:0]  = $urandom;
				w[35:32] = WEIGHT_W'($urandom_range(0, 15));
			end
			WT_UNIT:   w = WEIGHTS_RST;
			WT_ZERO:   w = '0;
			WT_SINGLE: w[WEIGHT_W*tap +: WEIGHT_W] = WEIGHT_W'($urandom_range(1, 15));
			WT_FULL:   w = '1;
			WT_LIGHT: begin
				for (int i = 0; i < WIN_TAPS; i++)
					w[WEIGHT_W*i +: WEIGHT_W] = WEIGHT_W'($urandom_range(0, 2));
			end
			default: ;
		endcase
		return w;
	endfunction

	task automatic push_one(input pix_t value, input logic first);
		pixel_req_t req;
		req.value = value;
		req.first = first;
		req.gap   = $urandom_range(0, GAP_MAX);
		pixel_queue.push_back(req);
	endtask

	// Queues a stream of random pixels. Frame starts are marked on some frame
	// boundaries; with noise on, a stray frame_start now and then restarts the
	// frame in the middle. Some streams draw from four levels only, so that
	// windows are full of equal values.
	task automatic push_stream(input int count, input int frame_len, input bit quiet,
			input bit start_mark, input bit noisy);
		pixel_req_t req;
		bit         narrow;
		narrow = ($urandom_range(0, 2) == 0);
		for (int i = 0; i < count; i++) begin
			req.value = narrow ? pix_t'($urandom_range(0, 3) * 85)
				: pix_t'($urandom_range(0, 255));
			if (i == 0)
				req.first = start_mark;
			else
				req.first = ((i % frame_len == 0) && $urandom_range(0, 1) == 1)
					|| (noisy && $urandom_range(0, 99) == 0);
			req.gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
			pixel_queue.push_back(req);
		end
	endtask

	// Main sequence.
	initial begin
		int               produced;
		int               count;
		int               ew;
		int               eh;
		int               sel;
		int               guard;
		logic [LW_W-1:0]  lw;
		logic [FH_W-1:0]  fh;
		bit               quiet;

		arst_n      = 1'b0;
		pix_valid   = 1'b0;
		pixel       = '0;
		frame_start = 1'b0;
		res_stall   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		errors      = 0;
		cur_loaded  = 1'b0;
		cur_wait    = 0;
		pix_taken   = 1'b0;
		res_taken   = 1'b0;
		rx_wait     = 0;
		hold_left   = 0;
		rx_quiet    = 1'b0;

		// Model state after reset. The block's line memory is not cleared,
		// but no frame below ever reads a column it has not written first.
		width_reg  = LINE_WIDTH_RST;
		height_reg = FRAME_HEIGHT_RST;
		weight_reg = WEIGHTS_RST;
		for (int i = 0; i < 2 * MAX_W; i++)
			line_mem[i] = '0;
		win_taps = '0;
		col_pos  = 0;
		row_pos  = 0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Power-on geometry and weights, untouched: 640 wide, no frame_start
		// on the first pixel. A short run inside the first line, which must
		// not produce any result.
		push_stream(40, 640 * 480, 1'b0, 1'b0, 1'b0);

		// Width and height below the minimum clamp to a 3x3 frame. A
		// checkerboard of the extreme values gives one median, flagged as the
		// last of the frame.
		setup(11'd2, 12'd1, WEIGHTS_RST, 1'b0);
		for (int i = 0; i < 9; i++)
			push_one((i % 2 == 0) ? 8'd255 : 8'd0, i == 0);

		// Same frame again with all weights zero, so the centre passes
		// through. No frame_start: the counters must have wrapped by
		// themselves.
		setup(11'd2, 12'd1, '0, 1'b0);
		for (int i = 0; i < 9; i++)
			push_one((i == 0) ? 8'd0 : ((i == 8) ? 8'd255 : pix_t'($urandom_range(0, 255))),
				1'b0);

		// Back pressure: the receiver holds off for a long stretch while the
		// sender offers a gap-free stream, so the pipeline fills and the
		// pixel side has to stall.
		setup(11'd4, 12'd200, WEIGHTS_RST, 1'b1);
		push_stream(120, 4 * 200, 1'b1, 1'b1, 1'b0);
		hold_left = HOLD_CYCLES;

		// Random phases: mostly small frames so that results are frequent,
		// sometimes clamped or wider geometry, and random weight patterns.
		produced = 0;
		while (produced < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 9);
			if (sel < 8)
				lw = LW_W'($urandom_range(3, 8));
			else if (sel == 8)
				lw = LW_W'($urandom_range(0, 2));
			else
				lw = LW_W'($urandom_range(9, 24));
			fh    = ($urandom_range(0, 6) == 0) ? FH_W'($urandom_range(0, 2))
				: FH_W'($urandom_range(3, 6));
			ew    = (lw < MIN_DIM) ? MIN_DIM : int'(lw);
			eh    = (fh < MIN_DIM) ? MIN_DIM : int'(fh);
			quiet = ($urandom_range(0, 3) == 0);
			count = $urandom_range(1, 3) * ew * eh + $urandom_range(0, 2 * ew);
			setup(lw, fh, pick_weights(), quiet);
			push_stream(count, ew * eh, quiet, 1'b1, 1'b1);
			produced += count;
		end

		// The tallest frame the height register allows.
		setup(11'd5, 12'd4095, pick_weights(), 1'b0);
		push_stream(100, 5 * 4095, 1'b0, 1'b1, 1'b1);

		// The widest line: an over-range width clamps to the full line store,
		// so a short run stays inside the first line and makes no result.
		setup(11'd2047, 12'd3, pick_weights(), 1'b0);
		push_stream(40, 3 * MAX_W, 1'b0, 1'b1, 1'b0);

		// Final drain with a bound, so that a missing result is reported as a
		// leftover rather than only through the watchdog.
		for (guard = 0; guard < DRAIN_LIMIT
				&& (pixel_queue.size() != 0 || cur_loaded || median_queue.size() != 0);
				guard++)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (median_queue.size() != 0) begin
			$error("%0d expected medians never arrived", median_queue.size());
			errors++;
		end

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
